// ===== design/dghc_pkg.sv =====
// ============================================================================
// dghc_pkg: shared types and constants of the die grid histogram checker
// Holds the sizes, the configuration register indexes, the word structs of
// both channels and the helper that limits a grid side to its legal range.
// ============================================================================
`default_nettype none

package dghc_pkg;

    // Number of faces of a die and the largest grid side.
    localparam int FACE_COUNT = 6;
    localparam int MAX_SIDE   = 64;

    // Widths derived from the sizes above and from the fixed field widths.
    localparam int ROLL_W     = 3;
    localparam int CNT_W      = 8;
    localparam int FAIL_W     = 7;
    localparam int IDX_W      = $clog2(MAX_SIDE);
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [FAIL_W-1:0] FAIL_MAX = {FAIL_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd3;

    // Register values after reset.
    localparam logic [CNT_W-1:0]  RST_MIN_COUNT   = 8'd15;
    localparam logic [CNT_W-1:0]  RST_MAX_COUNT   = 8'd18;
    localparam logic [SIDE_W-1:0] RST_GRID_WIDTH  = 7'd8;
    localparam logic [SIDE_W-1:0] RST_GRID_HEIGHT = 7'd8;

    typedef struct packed {
        logic [ROLL_W-1:0] roll_value;
        logic              last_roll;
    } t_in_word;

    typedef struct packed {
        logic             die_ok;
        logic [IDX_W-1:0] die_row;
        logic [IDX_W-1:0] die_col;
        logic             grid_error;
        logic             grid_done;
    } t_out_word;

    // A side of zero acts as one, a side beyond the largest acts as the largest.
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/dghc_ram.sv =====
// ============================================================================
// dghc_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
`default_nettype none

module dghc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/dghc_face_hist.sv =====
// ============================================================================
// dghc_face_hist: per-die face histogram and limit check
// Counts each face of the current die and judges the die on its last roll.
// ============================================================================
`default_nettype none

module dghc_face_hist (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_fire,
    input  wire logic [dghc_pkg::ROLL_W-1:0]        i_roll,
    input  wire logic                               i_last,
    input  wire logic [dghc_pkg::CNT_W-1:0]         i_min_count,
    input  wire logic [dghc_pkg::CNT_W-1:0]         i_max_count,
    output logic                                    o_die_ok
);

    logic [dghc_pkg::CNT_W-1:0] r_cnt [dghc_pkg::FACE_COUNT];
    logic [dghc_pkg::CNT_W-1:0] n_cnt [dghc_pkg::FACE_COUNT];
    logic                       r_bad;
    logic                       n_bad;
    logic                       roll_bad;
    logic                       in_range;
    logic                       cnt_clear;

    // Counts including this roll; the die is judged on these.
    always_comb begin
        roll_bad = (i_roll == '0) ||
                   (i_roll > dghc_pkg::ROLL_W'(dghc_pkg::FACE_COUNT));
        in_range = 1'b1;
        for (int f = 0; f < dghc_pkg::FACE_COUNT; f++) begin
            if ((i_roll == dghc_pkg::ROLL_W'(f + 1)) &&
                (r_cnt[f] != dghc_pkg::CNT_MAX)) begin
                n_cnt[f] = r_cnt[f] + dghc_pkg::CNT_W'(1);
            end else begin
                n_cnt[f] = r_cnt[f];
            end
            if ((n_cnt[f] < i_min_count) || (n_cnt[f] > i_max_count)) begin
                in_range = 1'b0;
            end
        end
        n_bad     = r_bad | roll_bad;
        o_die_ok  = in_range && !n_bad;
        cnt_clear = i_fire && i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < dghc_pkg::FACE_COUNT; f++) begin
                r_cnt[f] <= '0;
            end
            r_bad <= 1'b0;
        end else if (i_fire) begin
            for (int f = 0; f < dghc_pkg::FACE_COUNT; f++) begin
                r_cnt[f] <= cnt_clear ? '0 : n_cnt[f];
            end
            r_bad <= cnt_clear ? 1'b0 : n_bad;
        end
    end

    logic all_clear;
    always_comb begin
        all_clear = !r_bad;
        for (int f = 0; f < dghc_pkg::FACE_COUNT; f++) begin
            if (r_cnt[f] != '0) begin
                all_clear = 1'b0;
            end
        end
    end

    // A finished die leaves an empty histogram behind.
    a_clear_after_die: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_last) |=> all_clear)
        else $error("face histogram not cleared after the last roll of a die");

    // A bad roll always fails its die.
    a_bad_roll_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && roll_bad) |-> !o_die_ok)
        else $error("die passed despite an out-of-range roll");

    // Counts never move without an accepted roll; this check covers the bad-roll flag.
    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_bad))
        else $error("bad-roll flag changed without an accepted roll");

endmodule

`default_nettype wire

// ===== design/die_grid_histogram_checker_unit.sv =====
// ============================================================================
// die_grid_histogram_checker_unit: grid-of-dice roll histogram checker
// Takes die rolls, judges every die on its face histogram, and tracks failed
// dice per row and per column of the grid with a sticky grid error flag.
// ============================================================================
//
// Usage. Rolls enter one word per cycle on the input channel (valid/ready);
// the last_roll bit closes the current die. Dice arrive in row-major order.
// For every closed die one result word leaves on the output channel, carrying
// the pass flag, the die's row and column, the sticky grid error and a mark on
// the last die of the grid. Rolls that do not close a die produce no word.
//
// Latency and throughput. A roll is handled in the cycle it is accepted; its
// result word is valid the next cycle from the output register. The block
// takes one roll every cycle unless stalled, dice of a single roll included;
// the per-column failure counts live in a small RAM whose read address runs
// one die ahead, with a write bypass for a column that is read back at once.
//
// Stalls. Input ready stays high while the output register is empty or is
// being emptied in the same cycle, so a stalled receiver holds back the input
// only once a result word is waiting.
//
// Reset. The synchronous active-low reset restores the configuration
// registers to their defaults and clears all grid state at once; the column
// counts are cleared through per-column valid bits, so no clearing pass runs.
// The same clearing happens after the last die of each grid.
// ============================================================================
`default_nettype none

module die_grid_histogram_checker_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Roll input channel.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire dghc_pkg::t_in_word                i_in_data,
    // Die result channel.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output dghc_pkg::t_out_word                    o_out_data,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [dghc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [dghc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [dghc_pkg::CNT_W-1:0]  r_min_count;
    logic [dghc_pkg::CNT_W-1:0]  r_max_count;
    logic [dghc_pkg::SIDE_W-1:0] r_grid_width;
    logic [dghc_pkg::SIDE_W-1:0] r_grid_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_count   <= dghc_pkg::RST_MIN_COUNT;
            r_max_count   <= dghc_pkg::RST_MAX_COUNT;
            r_grid_width  <= dghc_pkg::RST_GRID_WIDTH;
            r_grid_height <= dghc_pkg::RST_GRID_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dghc_pkg::CFG_MIN_COUNT: begin
                    r_min_count <= i_cfg_data[dghc_pkg::CNT_W-1:0];
                end
                dghc_pkg::CFG_MAX_COUNT: begin
                    r_max_count <= i_cfg_data[dghc_pkg::CNT_W-1:0];
                end
                dghc_pkg::CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[dghc_pkg::SIDE_W-1:0];
                end
                dghc_pkg::CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[dghc_pkg::SIDE_W-1:0];
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A word is accepted when the output register has room.
    // ------------------------------------------------------------------
    logic fire;
    logic die_end;

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;
    assign die_end    = fire && i_in_data.last_roll;

    // ------------------------------------------------------------------
    // Per-die histogram and limit check.
    // ------------------------------------------------------------------
    logic die_ok;

    dghc_face_hist u_face_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_roll      (i_in_data.roll_value),
        .i_last      (i_in_data.last_roll),
        .i_min_count (r_min_count),
        .i_max_count (r_max_count),
        .o_die_ok    (die_ok)
    );

    // ------------------------------------------------------------------
    // Grid position, row failures and the sticky error flag.
    // ------------------------------------------------------------------
    logic [dghc_pkg::IDX_W-1:0]    r_col;
    logic [dghc_pkg::IDX_W-1:0]    n_col;
    logic [dghc_pkg::IDX_W-1:0]    r_row;
    logic [dghc_pkg::IDX_W-1:0]    n_row;
    logic [dghc_pkg::FAIL_W-1:0]   r_row_fail;
    logic [dghc_pkg::FAIL_W-1:0]   n_row_fail;
    logic                          r_err;
    logic                          n_err;
    logic [dghc_pkg::MAX_SIDE-1:0] r_col_vld;
    logic [dghc_pkg::MAX_SIDE-1:0] n_col_vld;

    // Column failure count store, its read side and the write bypass.
    logic                          ram_we;
    logic [dghc_pkg::FAIL_W-1:0]   ram_rdata;
    logic                          r_rd_vld;
    logic                          r_byp;
    logic [dghc_pkg::FAIL_W-1:0]   r_byp_data;
    logic                          n_byp;

    logic [dghc_pkg::SIDE_W-1:0]   eff_w;
    logic [dghc_pkg::SIDE_W-1:0]   eff_h;
    logic [dghc_pkg::FAIL_W-1:0]   col_cnt;
    logic [dghc_pkg::FAIL_W-1:0]   col_cnt_new;
    logic [dghc_pkg::FAIL_W-1:0]   row_fail_new;
    logic                          die_fail;
    logic                          end_row;
    logic                          grid_done;
    logic                          err_new;

    always_comb begin
        eff_w    = dghc_pkg::eff_side(r_grid_width);
        eff_h    = dghc_pkg::eff_side(r_grid_height);
        die_fail = !die_ok;

        // Failure count of the current column as it stands before this die.
        if (r_byp) begin
            col_cnt = r_byp_data;
        end else if (r_rd_vld) begin
            col_cnt = ram_rdata;
        end else begin
            col_cnt = '0;
        end

        col_cnt_new = (col_cnt != dghc_pkg::FAIL_MAX) ?
                      col_cnt + dghc_pkg::FAIL_W'(1) : col_cnt;
        if (die_fail && (r_row_fail != dghc_pkg::FAIL_MAX)) begin
            row_fail_new = r_row_fail + dghc_pkg::FAIL_W'(1);
        end else begin
            row_fail_new = r_row_fail;
        end

        // An index at or past the last one of the current size closes the row
        // or the grid, which also covers a size shrunk in the middle of a grid.
        end_row   = (dghc_pkg::SIDE_W'(r_col) + dghc_pkg::SIDE_W'(1)) >= eff_w;
        grid_done = end_row &&
                    ((dghc_pkg::SIDE_W'(r_row) + dghc_pkg::SIDE_W'(1)) >= eff_h);

        // The column test only runs on a failed die, the row test at every
        // row end; both thresholds are half the side, rounded down.
        err_new = r_err ||
                  (die_fail &&
                   (dghc_pkg::SIDE_W'(col_cnt_new) >= (eff_h >> 1))) ||
                  (end_row &&
                   (dghc_pkg::SIDE_W'(row_fail_new) >= (eff_w >> 1)));

        n_col      = r_col;
        n_row      = r_row;
        n_row_fail = r_row_fail;
        n_err      = r_err;
        n_col_vld  = r_col_vld;
        if (die_end) begin
            if (grid_done) begin
                n_col      = '0;
                n_row      = '0;
                n_row_fail = '0;
                n_err      = 1'b0;
                n_col_vld  = '0;
            end else begin
                n_err = err_new;
                if (die_fail) begin
                    n_col_vld[r_col] = 1'b1;
                end
                if (end_row) begin
                    n_col      = '0;
                    n_row      = r_row + dghc_pkg::IDX_W'(1);
                    n_row_fail = '0;
                end else begin
                    n_col      = r_col + dghc_pkg::IDX_W'(1);
                    n_row_fail = row_fail_new;
                end
            end
        end

        // The store is only written while the grid goes on; a finished grid
        // drops every column count through the valid bits instead.
        ram_we = die_end && die_fail && !grid_done;
        // The next die may sit in the column just written (width of one).
        n_byp  = ram_we && (r_col == n_col);
    end

    // The read address follows the next column, so its count is ready when
    // the next die closes.
    dghc_ram #(
        .WIDTH (dghc_pkg::FAIL_W),
        .DEPTH (dghc_pkg::MAX_SIDE)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (col_cnt_new),
        .i_raddr (n_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_row_fail <= '0;
            r_err      <= 1'b0;
            r_col_vld  <= '0;
            r_rd_vld   <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_row_fail <= n_row_fail;
            r_err      <= n_err;
            r_col_vld  <= n_col_vld;
            r_rd_vld   <= n_col_vld[n_col];
            r_byp      <= n_byp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= col_cnt_new;
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (die_end) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (die_end) begin
            o_out_data.die_ok     <= die_ok;
            o_out_data.die_row    <= r_row;
            o_out_data.die_col    <= r_col;
            o_out_data.grid_error <= err_new;
            o_out_data.grid_done  <= grid_done;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Every closed die leaves a result word behind.
    a_die_makes_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        die_end |=> o_out_valid)
        else $error("closed die produced no result word");

    // The last die of a grid brings the grid state back to its start.
    a_grid_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (die_end && grid_done) |=>
            (r_col == '0) && (r_row == '0) && !r_err && (r_col_vld == '0) &&
            !r_rd_vld && !r_byp)
        else $error("grid state not cleared after the last die");

    // The error flag only drops at the end of a grid.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !(die_end && grid_done)) |=> r_err)
        else $error("grid error flag dropped in the middle of a grid");

    // A bypassed count always belongs to a column marked as written.
    a_byp_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> (r_rd_vld && r_col_vld[r_col]))
        else $error("bypass active for a column without a stored count");

    // Position only moves when a die closes.
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !die_end |=> ($stable(r_col) && $stable(r_row)))
        else $error("grid position moved without a closed die");

endmodule

`default_nettype wire
